### rtl/core/jep_pkg.sv
package jep_pkg;

  localparam int SEAT_W        = 7;
  localparam int SKIP_W        = 8;
  localparam int MAX_SEATS_DEF = 64;

  typedef struct packed {
    logic [SEAT_W-1:0] seat_count;
    logic [SKIP_W-1:0] skip;
  } in_word_t;

  typedef struct packed {
    logic [SEAT_W-1:0] seat;
    logic              last;
  } out_word_t;

  // sequencer step codes
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] S_IDLE    = 3'd0;
  localparam logic [STEP_W-1:0] S_BUILD   = 3'd1;
  localparam logic [STEP_W-1:0] S_INIT    = 3'd2;
  localparam logic [STEP_W-1:0] S_READ    = 3'd3;
  localparam logic [STEP_W-1:0] S_ADVANCE = 3'd4;
  localparam logic [STEP_W-1:0] S_REMOVE  = 3'd5;
  localparam logic [STEP_W-1:0] S_FINAL   = 3'd6;

  // datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_START   = 3'd1;
  localparam logic [OP_W-1:0] OP_BUILD   = 3'd2;
  localparam logic [OP_W-1:0] OP_INIT    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_ADVANCE = 3'd5;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd6;
  localparam logic [OP_W-1:0] OP_FINAL   = 3'd7;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_ALWAYS     = 3'd0;
  localparam logic [COND_W-1:0] C_IDLE_STAY  = 3'd1;
  localparam logic [COND_W-1:0] C_BUILD_MORE = 3'd2;
  localparam logic [COND_W-1:0] C_SINGLE     = 3'd3;
  localparam logic [COND_W-1:0] C_WALK_DONE  = 3'd4;
  localparam logic [COND_W-1:0] C_MORE       = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      S_IDLE:    w = '{op: OP_START,   cond: C_IDLE_STAY,  target: S_IDLE};
      S_BUILD:   w = '{op: OP_BUILD,   cond: C_BUILD_MORE, target: S_BUILD};
      S_INIT:    w = '{op: OP_INIT,    cond: C_SINGLE,     target: S_FINAL};
      S_READ:    w = '{op: OP_READ,    cond: C_WALK_DONE,  target: S_REMOVE};
      S_ADVANCE: w = '{op: OP_ADVANCE, cond: C_ALWAYS,     target: S_READ};
      S_REMOVE:  w = '{op: OP_REMOVE,  cond: C_MORE,       target: S_READ};
      S_FINAL:   w = '{op: OP_FINAL,   cond: C_ALWAYS,     target: S_IDLE};
      default:   w = '{op: OP_NONE,    cond: C_ALWAYS,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/josephus_elimination_order.sv
// Josephus elimination order. A request (seat_count n, skip k) is taken only while the
// sequencer is idle; it builds the successor ring, one table write a cycle, then walks the
// ring through the successor memory (one write port, one registered read port), each hop a
// read step then an advance step, and emits each removed seat, the survivor last with last
// set. An output stall holds the sequencer in its remove and final steps.
// seat_count 0 gives no result, seat_count above MAX_SEATS is cut to MAX_SEATS, skip 0 acts as 1.
module josephus_elimination_order #(
  parameter int MAX_SEATS = jep_pkg::MAX_SEATS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jep_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output jep_pkg::out_word_t out_word
);

  localparam int IDX_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
  localparam int CNT_W = $clog2(MAX_SEATS + 1);
  localparam int SW    = jep_pkg::SEAT_W;
  localparam int KW    = jep_pkg::SKIP_W;

  logic [jep_pkg::STEP_W-1:0] upc_r, upc_nxt;
  jep_pkg::ucode_t            uw;

  logic [CNT_W-1:0] n_r, n_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;

  logic [IDX_W-1:0] succ_mem [MAX_SEATS];
  logic [IDX_W-1:0] rdata_r;
  logic             we;
  logic [IDX_W-1:0] waddr, wdata;
  logic             re;

  logic               out_valid_r, out_valid_nxt;
  jep_pkg::out_word_t out_word_r, out_word_nxt;

  logic [CNT_W-1:0] n_in;
  logic [KW-1:0]    k_in;
  logic             accept, emit_ok, hold, cond_true, last_build;

  assign uw = jep_pkg::ucode_rom(upc_r);

  // clamp the request
  always_comb begin
    if (in_word.seat_count > SW'(MAX_SEATS)) begin
      n_in = CNT_W'(MAX_SEATS);
    end else begin
      n_in = CNT_W'(in_word.seat_count);
    end
    k_in = (in_word.skip == '0) ? KW'(1) : in_word.skip;
  end

  assign accept     = in_valid && (upc_r == jep_pkg::S_IDLE);
  assign in_stall   = (upc_r != jep_pkg::S_IDLE);
  assign emit_ok    = !out_valid_r || !out_stall;
  assign hold       = ((uw.op == jep_pkg::OP_REMOVE) || (uw.op == jep_pkg::OP_FINAL)) && !emit_ok;
  assign last_build = ((CNT_W'(i_r) + CNT_W'(1)) == n_r);

  always_comb begin
    unique case (uw.cond)
      jep_pkg::C_ALWAYS:     cond_true = 1'b1;
      jep_pkg::C_IDLE_STAY:  cond_true = !accept || (n_in == '0);
      jep_pkg::C_BUILD_MORE: cond_true = !last_build;
      jep_pkg::C_SINGLE:     cond_true = (n_r == CNT_W'(1));
      jep_pkg::C_WALK_DONE:  cond_true = (j_r >= k_r);
      jep_pkg::C_MORE:       cond_true = (rem_r > CNT_W'(2));
      default:               cond_true = 1'b1;
    endcase
  end

  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    i_nxt         = i_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    we            = 1'b0;
    waddr         = prev_r;
    wdata         = rdata_r;
    re            = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = cond_true ? uw.target : upc_r + jep_pkg::STEP_W'(1);
      unique case (uw.op)
        jep_pkg::OP_START: begin
          n_nxt = n_in;
          k_nxt = k_in;
          i_nxt = '0;
        end
        jep_pkg::OP_BUILD: begin
          we    = 1'b1;
          waddr = i_r;
          wdata = last_build ? '0 : i_r + IDX_W'(1);
          i_nxt = i_r + IDX_W'(1);
        end
        jep_pkg::OP_INIT: begin
          cur_nxt  = '0;
          prev_nxt = IDX_W'(n_r - CNT_W'(1));
          rem_nxt  = n_r;
          j_nxt    = KW'(1);
        end
        jep_pkg::OP_READ: begin
          re = 1'b1;
        end
        jep_pkg::OP_ADVANCE: begin
          prev_nxt = cur_r;
          cur_nxt  = rdata_r;
          j_nxt    = j_r + KW'(1);
        end
        jep_pkg::OP_REMOVE: begin
          // unlink cur: prev now points past it
          we            = 1'b1;
          waddr         = prev_r;
          wdata         = rdata_r;
          cur_nxt       = rdata_r;
          rem_nxt       = rem_r - CNT_W'(1);
          j_nxt         = KW'(1);
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{seat: SW'(cur_r) + SW'(1), last: 1'b0};
        end
        jep_pkg::OP_FINAL: begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{seat: SW'(cur_r) + SW'(1), last: 1'b1};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      succ_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= succ_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= jep_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
      rem_r       <= '0;
      i_r         <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      rem_r       <= rem_nxt;
      i_r         <= i_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= jep_pkg::S_FINAL)
    else $error("sequencer step out of range");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == jep_pkg::S_READ || upc_r == jep_pkg::S_ADVANCE ||
     upc_r == jep_pkg::S_REMOVE) |-> (rem_r > CNT_W'(1) && rem_r <= n_r))
    else $error("remaining seat count out of range during walk");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == jep_pkg::S_READ || upc_r == jep_pkg::S_ADVANCE) |->
    (j_r >= KW'(1) && j_r <= k_r))
    else $error("walk counter passed skip");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == jep_pkg::S_FINAL && emit_ok) |=> (upc_r == jep_pkg::S_IDLE && out_valid_r &&
    out_word_r.last))
    else $error("survivor not emitted on leaving final step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r != jep_pkg::S_IDLE) |=> $stable(n_r) && $stable(k_r))
    else $error("request registers changed mid run");

endmodule
